[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SAC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sac_pkg.sv]
// ----------------------------------------------------------------------------
// sac_pkg
// Shared constants, types and codes of the stack calculator.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int DEPTH_W     = 5;
    localparam int STEP_W      = $clog2(WORD_W);

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [STEP_W-1:0]  step_t;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_REPORT = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    localparam step_t STEP_LAST = step_t'(WORD_W - 1);

endpackage

[src/sac_ram.sv]
// ----------------------------------------------------------------------------
// sac_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[src/stack_arithmetic_calculator.sv]
// ----------------------------------------------------------------------------
// stack_arithmetic_calculator
// RPN calculator on a bounded stack of 32-bit signed values held in a RAM.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    opcode, operand
//   out      out_valid / out_stall  top_value, status, depth
//
// One beat in gives one beat out. One item is worked at a time.
// Push, add, subtract, multiply and report: the input beat passes S_EXEC, then
// S_FIN loads the out beat. Divide: S_EXEC, then 32 steps of the radix-2
// restoring divider in S_DIV, sign fix in S_DFIX and output load in S_FIN.
// The next input beat is taken the cycle after the result is loaded.
// A result held by out_stall parks the block before the stack write-back.
// Reset clears the stack count; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module stack_arithmetic_calculator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] operand,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] top_value,
    output logic [1:0]         status,
    output logic [4:0]         depth
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DFIX,
        S_FIN
    } state_t;

    state_t                  state_reg;
    sac_pkg::op_t            op_reg;
    sac_pkg::word_t          opnd_reg;
    sac_pkg::cnt_t           cnt_reg;
    sac_pkg::cnt_t           pend_cnt_reg;
    sac_pkg::word_t          res_reg;
    sac_pkg::status_t        st_reg;
    logic                    wr_pend_reg;
    sac_pkg::addr_t          wr_addr_reg;
    sac_pkg::word_t          quo_reg;
    sac_pkg::word_t          rem_reg;
    sac_pkg::word_t          den_reg;
    logic                    neg_reg;
    sac_pkg::step_t          step_reg;
    logic                    out_valid_reg;
    sac_pkg::word_t          top_value_reg;
    sac_pkg::status_t        status_reg;
    sac_pkg::depth_t         depth_reg;

    sac_pkg::cnt_t           cnt_m1;
    sac_pkg::cnt_t           cnt_m2;
    sac_pkg::addr_t          raddr_a;
    sac_pkg::addr_t          raddr_b;
    sac_pkg::word_t          t_word;
    sac_pkg::word_t          b_word;
    sac_pkg::word_t          t_mag;
    sac_pkg::word_t          b_mag;
    sac_pkg::word_t          prod;
    sac_pkg::word_t          rem_sh;
    logic [sac_pkg::WORD_W:0] diff;
    logic                    out_free;
    logic                    ram_we;

    assign cnt_m1  = cnt_reg - sac_pkg::cnt_t'(1);
    assign cnt_m2  = cnt_reg - sac_pkg::cnt_t'(2);
    assign raddr_a = cnt_m1[sac_pkg::ADDR_W-1:0];
    assign raddr_b = cnt_m2[sac_pkg::ADDR_W-1:0];

    assign t_mag = t_word[sac_pkg::WORD_W-1] ? (sac_pkg::word_t'(0) - t_word) : t_word;
    assign b_mag = b_word[sac_pkg::WORD_W-1] ? (sac_pkg::word_t'(0) - b_word) : b_word;
    assign prod  = b_word * t_word;

    // restoring divide step
    assign rem_sh = {rem_reg[sac_pkg::WORD_W-2:0], quo_reg[sac_pkg::WORD_W-1]};
    assign diff   = {1'b0, rem_sh} - {1'b0, den_reg};

    assign out_free = !out_valid_reg || !out_stall;
    assign ram_we   = (state_reg == S_FIN) && out_free && wr_pend_reg;

    sac_ram #(
        .WIDTH (sac_pkg::WORD_W),
        .DEPTH (sac_pkg::STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (wr_addr_reg),
        .wdata   (res_reg),
        .raddr_a (raddr_a),
        .rdata_a (t_word),
        .raddr_b (raddr_b),
        .rdata_b (b_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= sac_pkg::op_t'(opcode);
                        opnd_reg  <= operand;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_reg      <= '0;
                    st_reg       <= sac_pkg::ST_OK;
                    wr_pend_reg  <= 1'b0;
                    wr_addr_reg  <= raddr_b;
                    pend_cnt_reg <= cnt_reg;
                    state_reg    <= S_FIN;
                    case (op_reg)
                        sac_pkg::OP_PUSH:
                        begin
                            if (cnt_reg >= sac_pkg::cnt_t'(sac_pkg::STACK_DEPTH))
                            begin
                                st_reg <= sac_pkg::ST_OVER;
                            end
                            else
                            begin
                                res_reg      <= opnd_reg;
                                wr_pend_reg  <= 1'b1;
                                wr_addr_reg  <= cnt_reg[sac_pkg::ADDR_W-1:0];
                                pend_cnt_reg <= cnt_reg + sac_pkg::cnt_t'(1);
                            end
                        end
                        sac_pkg::OP_ADD, sac_pkg::OP_SUB, sac_pkg::OP_MUL, sac_pkg::OP_DIV:
                        begin
                            if (cnt_reg < sac_pkg::cnt_t'(2))
                            begin
                                st_reg <= sac_pkg::ST_UNDER;
                            end
                            else if (op_reg == sac_pkg::OP_DIV && t_word == '0)
                            begin
                                st_reg <= sac_pkg::ST_DIVZ;
                            end
                            else
                            begin
                                wr_pend_reg  <= 1'b1;
                                pend_cnt_reg <= cnt_m1;
                                case (op_reg)
                                    sac_pkg::OP_ADD: res_reg <= b_word + t_word;
                                    sac_pkg::OP_SUB: res_reg <= b_word - t_word;
                                    sac_pkg::OP_MUL: res_reg <= prod;
                                    default:
                                    begin
                                        quo_reg   <= b_mag;
                                        rem_reg   <= '0;
                                        den_reg   <= t_mag;
                                        neg_reg   <= b_word[sac_pkg::WORD_W-1] ^
                                                     t_word[sac_pkg::WORD_W-1];
                                        step_reg  <= '0;
                                        state_reg <= S_DIV;
                                    end
                                endcase
                            end
                        end
                        sac_pkg::OP_REPORT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_reg <= sac_pkg::ST_UNDER;
                            end
                            else
                            begin
                                res_reg      <= t_word;
                                pend_cnt_reg <= cnt_m1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (diff[sac_pkg::WORD_W])
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[sac_pkg::WORD_W-2:0], 1'b0};
                    end
                    else
                    begin
                        rem_reg <= diff[sac_pkg::WORD_W-1:0];
                        quo_reg <= {quo_reg[sac_pkg::WORD_W-2:0], 1'b1};
                    end
                    step_reg <= step_reg + sac_pkg::step_t'(1);
                    if (step_reg == sac_pkg::STEP_LAST)
                    begin
                        state_reg <= S_DFIX;
                    end
                end
                S_DFIX:
                begin
                    res_reg   <= neg_reg ? (sac_pkg::word_t'(0) - quo_reg) : quo_reg;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        top_value_reg <= res_reg;
                        status_reg    <= st_reg;
                        depth_reg     <= sac_pkg::depth_t'(pend_cnt_reg);
                        cnt_reg       <= pend_cnt_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign top_value = top_value_reg;
    assign status    = status_reg;
    assign depth     = depth_reg;

endmodule

[src/sac_checker.sv]
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks of the stack calculator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] top_value,
    input logic [1:0]  status,
    input logic [4:0]  depth
);

    `SAC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(top_value) && $stable(status) && $stable(depth), "stalled out beat changed")

    `SAC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken before result")

    `SAC_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && (status != sac_pkg::ST_OK), top_value == '0, "error beat with nonzero value")

    `SAC_ASSERT_IMPLY(a_over_full, clk, rst_n, out_valid && (status == sac_pkg::ST_OVER), depth == sac_pkg::depth_t'(sac_pkg::STACK_DEPTH), "overflow while not full")

    `SAC_ASSERT_IMPLY(a_under_low, clk, rst_n, out_valid && (status == sac_pkg::ST_UNDER), depth <= sac_pkg::depth_t'(1), "underflow with two or more entries")

endmodule

bind stack_arithmetic_calculator sac_checker u_sac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .top_value (top_value),
    .status    (status),
    .depth     (depth)
);
